>>> rtl/ebv_pkg.sv
// Shared types and constants for the edge barrier validator.
package ebv_pkg;

  // Number of rectangle registers in the configuration map
  localparam int RECT_REGS = 4;

  // Configuration port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Coordinate widths: 16-bit input, 18 bits once a size has been added
  localparam int COORD_W = 16;
  localparam int SPAN_W  = 18;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT0 = 3'd1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_NOT_ALIGNED = 3'd1,
    ST_POINT       = 3'd2,
    ST_MULTIPLE    = 3'd3,
    ST_OVERLAP     = 3'd4,
    ST_PARTIAL     = 3'd5,
    ST_NO_EDGE     = 3'd6
  } status_t;

  // One monitor rectangle as packed in its register
  typedef struct packed {
    logic        [15:0] h;
    logic        [15:0] w;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } rect_t;

  // Segment and running verdict handed from cell to cell
  typedef struct packed {
    logic                      vert;   // segment runs along y
    logic signed [COORD_W-1:0] c;      // fixed coordinate
    logic signed [COORD_W-1:0] mn;     // low end along the segment
    logic signed [COORD_W-1:0] mx;     // high end along the segment
    logic                      done;   // verdict settled
    logic                      found;  // one border already holds it
    status_t                   status;
  } seg_t;

endpackage

>>> rtl/ebv_if.sv
// Valid/ready channel interfaces for segment requests, results and configuration.
interface ebv_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface ebv_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

interface ebv_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/edge_barrier_validator_core.sv
// Top level of the edge barrier validator: configuration registers and the cell chain.
// Checks each segment request against the configured monitor rectangles and returns one
// status code per request. A new request is taken every cycle unless a held result has
// filled the chain; a result passes one entry stage plus one cell per rectangle
// (NCELL = min(MAX_MONITORS, 4)) on its way out. Each cell holds a register stage, so a
// stalled result backs up the chain one stage at a time and the input keeps accepting
// while any stage is free. Configuration writes are taken every cycle and must only
// happen while no request is in flight; writes to rectangles beyond NCELL are dropped.
module edge_barrier_validator_core #(
  parameter int MAX_MONITORS = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  ebv_in_if.sink   in_if,
  ebv_out_if.source out_if,
  ebv_cfg_if.sink  cfg_if
);
  import ebv_pkg::*;

  localparam int NCELL = (MAX_MONITORS < RECT_REGS) ? MAX_MONITORS : RECT_REGS;

  logic [2:0] count_r;
  rect_t      rect_r [NCELL];

  logic       link_valid [NCELL+1];
  logic       link_ready [NCELL+1];
  seg_t       link       [NCELL+1];

  // Configuration writes are always taken
  assign cfg_if.ready = 1'b1;

  // Hold the rectangle count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd0;
    end else if (cfg_if.valid && cfg_if.index == REG_COUNT) begin
      count_r <= cfg_if.data[2:0];
    end
  end

  // Hold one rectangle per cell
  for (genvar i = 0; i < NCELL; i++) begin : g_rect
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rect_r[i] <= '0;
      end else if (cfg_if.valid && cfg_if.index == REG_RECT0 + CFG_IDX_W'(i)) begin
        rect_r[i] <= rect_t'(cfg_if.data);
      end
    end
  end

  ebv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_if.valid),
    .up_ready (in_if.ready),
    .start_x  (in_if.start_x),
    .start_y  (in_if.start_y),
    .end_x    (in_if.end_x),
    .end_y    (in_if.end_y),
    .dn_valid (link_valid[0]),
    .dn_ready (link_ready[0]),
    .dn       (link[0])
  );

  // One cell per rectangle, examined in index order
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ebv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .rect     (rect_r[i]),
      .active   (count_r > 3'(i)),
      .up_valid (link_valid[i]),
      .up_ready (link_ready[i]),
      .up       (link[i]),
      .dn_valid (link_valid[i+1]),
      .dn_ready (link_ready[i+1]),
      .dn       (link[i+1])
    );
  end

  // Last cell register is the result register
  assign out_if.valid       = link_valid[NCELL];
  assign out_if.status      = link[NCELL].status;
  assign link_ready[NCELL]  = out_if.ready;

endmodule

>>> rtl/ebv_front.sv
// Entry stage: register the segment, check alignment and length, order its ends.
module ebv_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic signed [15:0]        start_x,
  input  logic signed [15:0]        start_y,
  input  logic signed [15:0]        end_x,
  input  logic signed [15:0]        end_y,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output ebv_pkg::seg_t             dn
);
  import ebv_pkg::*;

  logic               valid_r;
  seg_t               seg_r;
  seg_t               seg_nxt;
  logic               same_x;
  logic               same_y;
  logic signed [15:0] a;
  logic signed [15:0] b;

  // Prepare segment: fixed coordinate, sorted range, early verdicts
  always_comb begin
    same_x = (start_x == end_x);
    same_y = (start_y == end_y);
    a      = same_x ? start_y : start_x;
    b      = same_x ? end_y   : end_x;

    seg_nxt.vert   = same_x;
    seg_nxt.c      = same_x ? start_x : start_y;
    seg_nxt.mn     = (a < b) ? a : b;
    seg_nxt.mx     = (a < b) ? b : a;
    seg_nxt.found  = 1'b0;
    seg_nxt.done   = 1'b0;
    seg_nxt.status = ST_NO_EDGE;
    priority if (!same_x && !same_y) begin
      seg_nxt.done   = 1'b1;
      seg_nxt.status = ST_NOT_ALIGNED;
    end else if (same_x && same_y) begin
      seg_nxt.done   = 1'b1;
      seg_nxt.status = ST_POINT;
    end else begin
      // Axis aligned with some length: leave the verdict to the cells
      seg_nxt.done   = 1'b0;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  // Advance whenever the next stage can take the held request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      seg_r <= seg_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn       = seg_r;

endmodule

>>> rtl/ebv_cell.sv
// One link of the chain: classify the segment against one rectangle and pass it on.
module ebv_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  ebv_pkg::rect_t rect,
  input  logic          active,
  input  logic          up_valid,
  output logic          up_ready,
  input  ebv_pkg::seg_t up,
  output logic          dn_valid,
  input  logic          dn_ready,
  output ebv_pkg::seg_t dn
);
  import ebv_pkg::*;

  logic                     valid_r;
  seg_t                     seg_r;
  seg_t                     seg_nxt;
  logic signed [SPAN_W-1:0] x_lo;
  logic signed [SPAN_W-1:0] x_hi;
  logic signed [SPAN_W-1:0] y_lo;
  logic signed [SPAN_W-1:0] y_hi;
  logic signed [SPAN_W-1:0] lo;
  logic signed [SPAN_W-1:0] hi;
  logic signed [SPAN_W-1:0] plo;
  logic signed [SPAN_W-1:0] phi;
  logic signed [SPAN_W-1:0] c;
  logic signed [SPAN_W-1:0] mn;
  logic signed [SPAN_W-1:0] mx;
  logic                     touch;
  logic                     on_border;
  logic                     spill;

  // Rectangle spans, both ends inclusive, no wrap
  always_comb begin
    x_lo = {{(SPAN_W-COORD_W){rect.x[COORD_W-1]}}, rect.x};
    y_lo = {{(SPAN_W-COORD_W){rect.y[COORD_W-1]}}, rect.y};
    x_hi = x_lo + {{(SPAN_W-COORD_W){1'b0}}, rect.w};
    y_hi = y_lo + {{(SPAN_W-COORD_W){1'b0}}, rect.h};
    lo   = up.vert ? x_lo : y_lo;
    hi   = up.vert ? x_hi : y_hi;
    plo  = up.vert ? y_lo : x_lo;
    phi  = up.vert ? y_hi : x_hi;
    c    = {{(SPAN_W-COORD_W){up.c[COORD_W-1]}},  up.c};
    mn   = {{(SPAN_W-COORD_W){up.mn[COORD_W-1]}}, up.mn};
    mx   = {{(SPAN_W-COORD_W){up.mx[COORD_W-1]}}, up.mx};
  end

  // Classify and fold into the running verdict
  always_comb begin
    touch     = (c >= lo) && (c <= hi) && (mx >= plo) && (mn <= phi);
    on_border = (c == lo) || (c == hi);
    spill     = (mx > phi) || (mn < plo);
    seg_nxt   = up;
    if (active && !up.done && touch) begin
      priority if (!on_border) begin
        seg_nxt.done   = 1'b1;
        seg_nxt.status = ST_OVERLAP;
      end else if (spill) begin
        seg_nxt.done   = 1'b1;
        seg_nxt.status = ST_PARTIAL;
      end else if (up.found) begin
        seg_nxt.done   = 1'b1;
        seg_nxt.status = ST_MULTIPLE;
      end else begin
        seg_nxt.found  = 1'b1;
        seg_nxt.status = ST_ACCEPTED;
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  // Advance whenever the next link can take the held request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      seg_r <= seg_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn       = seg_r;

endmodule

>>> rtl/ebv_checker.sv
// Port-level checks for the edge barrier validator, bound to the top level.
module ebv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status
);

  // Reset empties the chain
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Input stalls only when every stage is full and the result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the result side is free");

  // Hold a result until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_status))
    else $error("result changed while stalled");

endmodule

bind edge_barrier_validator_core ebv_checker u_ebv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_status (out_if.status)
);

>>> verif/edge_barrier_validator_core_test.sv
// Testbench for the edge barrier validator: random and directed segments checked by a scoreboard.
`timescale 1ns / 1ps

module edge_barrier_validator_core_test;
  import ebv_pkg::*;

  localparam int MAX_MON         = 4;
  localparam int NCELL           = (MAX_MON < RECT_REGS) ? MAX_MON : RECT_REGS;
  localparam int LATENCY         = NCELL + 1;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int HOLD_CYCLES     = 80;
  localparam int REPORT_MAX      = 10;

  typedef enum int {ADJ_NONE, ADJ_OVERLAP, ADJ_CONTAINED, ADJ_PARTIAL} adjacency_t;
  typedef enum int {RM_SMALL, RM_TILE, RM_WIDE, RM_BOUND} rect_mode_t;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
  } segment_t;

  // Predict the status of each segment request and compare against the block's results
  class status_scoreboard;
    logic [2:0] count_reg;
    rect_t      rect_reg [RECT_REGS];
    status_t    expected_q [$];
    int         mismatches;
    int         requests;
    int         results_seen;
    int         status_hits [8];

    function new();
      count_reg = '0;
      foreach (rect_reg[i]) rect_reg[i] = '0;
      foreach (status_hits[i]) status_hits[i] = 0;
      mismatches   = 0;
      requests     = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      if (idx == REG_COUNT) begin
        count_reg = data[2:0];
      end else if (int'(idx) >= int'(REG_RECT0) &&
                   int'(idx) < int'(REG_RECT0) + RECT_REGS) begin
        rect_reg[2'(idx - REG_RECT0)] = data;
      end
    endfunction

    // Place a segment on the line c along one axis against one rectangle span
    function adjacency_t classify(int c, int lo, int hi, int a, int b, int plo, int phi);
      int mn, mx;
      mn = (a < b) ? a : b;
      mx = (a < b) ? b : a;
      if (c < lo || c > hi) return ADJ_NONE;
      if (mx < plo || mn > phi) return ADJ_NONE;
      if (c == lo || c == hi) return (mx > phi || mn < plo) ? ADJ_PARTIAL : ADJ_CONTAINED;
      return ADJ_OVERLAP;
    endfunction

    function status_t predict(segment_t s);
      int x1, y1, x2, y2, rx, ry, rw, rh, n;
      adjacency_t adj;
      bit found;
      x1 = $signed(s.sx);
      y1 = $signed(s.sy);
      x2 = $signed(s.ex);
      y2 = $signed(s.ey);
      n  = count_reg;
      if (n > MAX_MON) n = MAX_MON;
      if (n > RECT_REGS) n = RECT_REGS;
      if (x1 != x2 && y1 != y2) return ST_NOT_ALIGNED;
      if (x1 == x2 && y1 == y2) return ST_POINT;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
        rx = $signed(rect_reg[i].x);
        ry = $signed(rect_reg[i].y);
        rw = rect_reg[i].w;
        rh = rect_reg[i].h;
        if (x1 == x2) adj = classify(x1, rx, rx + rw, y1, y2, ry, ry + rh);
        else          adj = classify(y1, ry, ry + rh, x1, x2, rx, rx + rw);
        if (adj == ADJ_OVERLAP) return ST_OVERLAP;
        if (adj == ADJ_PARTIAL) return ST_PARTIAL;
        if (adj == ADJ_CONTAINED) begin
          if (found) return ST_MULTIPLE;
          found = 1'b1;
        end
      end
      return found ? ST_ACCEPTED : ST_NO_EDGE;
    endfunction

    function void note_request(segment_t s);
      expected_q.push_back(predict(s));
      requests++;
    endfunction

    function void check_result(logic [2:0] got);
      status_t want;
      results_seen++;
      if (!$isunknown(got)) status_hits[got]++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: result %0d status %0d arrived with no request outstanding",
                   results_seen, got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: result %0d status expected %0d (%s) actual %0d",
                   results_seen, want, want.name(), got);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ebv_in_if  in_if ();
  ebv_out_if out_if ();
  ebv_cfg_if cfg_if ();

  edge_barrier_validator_core #(
    .MAX_MONITORS(MAX_MON)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  status_scoreboard sb = new();

  rect_t mon_rect [RECT_REGS];
  bit    tx_burst = 1'b0;
  bit    rx_burst = 1'b0;
  bit    hold_req = 1'b0;
  int    holds_done = 0;
  int    settings = 0;
  int    cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Observe every handshake: register writes, requests and results
  always @(posedge clk) begin
    if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)
      sb.write_reg(cfg_if.index, cfg_if.data);
    if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
      sb.note_request({in_if.start_x, in_if.start_y, in_if.end_x, in_if.end_y});
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result(out_if.status);
  end

  // Result receiver: random stalls, burst stretches and one long hold-off on request
  initial begin : result_sink
    int wait_cycles;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        wait_cycles = HOLD_CYCLES;
        hold_req    = 1'b0;
        holds_done++;
      end else if (rx_burst) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, 3);
      end
      if (wait_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
    end
  end

  function automatic int rnd_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic segment_t seg(int x1, int y1, int x2, int y2);
    return {16'(x1), 16'(y1), 16'(x2), 16'(y2)};
  endfunction

  function automatic rect_t rect_of(int x, int y, int w, int h);
    return {16'(h), 16'(w), 16'(y), 16'(x)};
  endfunction

  function automatic rect_t make_rect(rect_mode_t mode, rect_t prev);
    rect_t r;
    int w, h;
    w = ($urandom_range(0, 7) == 0) ? 0 : rnd_between(1, 300);
    h = ($urandom_range(0, 7) == 0) ? 0 : rnd_between(1, 300);
    case (mode)
      RM_SMALL: begin
        r = rect_of(rnd_between(-400, 400), rnd_between(-400, 400), w, h);
      end
      RM_TILE: begin
        // Butt against the previous rectangle so the two share a border
        if ($urandom_range(0, 1))
          r = rect_of($signed(prev.x) + int'(prev.w), $signed(prev.y), w,
                      $urandom_range(0, 1) ? int'(prev.h) : h);
        else
          r = rect_of($signed(prev.x), $signed(prev.y) + int'(prev.h),
                      $urandom_range(0, 1) ? int'(prev.w) : w, h);
      end
      RM_WIDE: begin
        r = {$urandom, $urandom};
      end
      default: begin
        // Hug the coordinate limits, with sizes that run past them
        case ($urandom_range(0, 2))
          0:       r.x = 16'sh8000;
          1:       r.x = 16'(32767 - rnd_between(0, 10));
          default: r.x = 16'($urandom);
        endcase
        case ($urandom_range(0, 2))
          0:       r.y = 16'sh8000;
          1:       r.y = 16'(32767 - rnd_between(0, 10));
          default: r.y = 16'($urandom);
        endcase
        case ($urandom_range(0, 2))
          0:       r.w = 16'd0;
          1:       r.w = 16'hffff;
          default: r.w = 16'($urandom);
        endcase
        case ($urandom_range(0, 2))
          0:       r.h = 16'd0;
          1:       r.h = 16'hffff;
          default: r.h = 16'($urandom);
        endcase
      end
    endcase
    return r;
  endfunction

  // Build an axis aligned segment on, inside or next to one border of a rectangle
  function automatic segment_t edge_segment(rect_t r);
    bit vert;
    int lo, hi, plo, phi, c, a, b, t;
    vert = 1'($urandom_range(0, 1));
    if (vert) begin
      lo  = $signed(r.x);
      hi  = lo + int'(r.w);
      plo = $signed(r.y);
      phi = plo + int'(r.h);
    end else begin
      lo  = $signed(r.y);
      hi  = lo + int'(r.h);
      plo = $signed(r.x);
      phi = plo + int'(r.w);
    end
    case ($urandom_range(0, 6))
      0, 1:    c = lo;
      2, 3:    c = hi;
      4:       c = (hi - lo >= 2) ? lo + 1 + rnd_between(0, hi - lo - 2) : lo;
      5:       c = lo - 1;
      default: c = hi + 1;
    endcase
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        a = rnd_between(plo, phi);
        b = rnd_between(plo, phi);
      end
      3: begin
        a = rnd_between(plo, phi);
        b = $urandom_range(0, 1) ? phi + 1 + rnd_between(0, 20) : plo - 1 - rnd_between(0, 20);
      end
      4: begin
        a = plo - rnd_between(0, 20);
        b = phi + rnd_between(0, 20);
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          a = phi + 1 + rnd_between(0, 40);
          b = a + 1 + rnd_between(0, 40);
        end else begin
          a = plo - 1 - rnd_between(0, 40);
          b = a - 1 - rnd_between(0, 40);
        end
      end
    endcase
    if (a == b) b = a + 1;
    if ($urandom_range(0, 1)) begin
      t = a;
      a = b;
      b = t;
    end
    return vert ? seg(c, a, c, b) : seg(a, c, b, c);
  endfunction

  // Mostly border segments of the loaded rectangles, the rest noise
  function automatic segment_t random_segment();
    segment_t s;
    rect_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r    = mon_rect[$urandom_range(0, RECT_REGS - 1)];
    s    = {$urandom, $urandom};
    if (pick < 10) begin
      if (s.ex == s.sx) s.ex = s.sx + 16'sd1;
      if (s.ey == s.sy) s.ey = s.sy + 16'sd1;
    end else if (pick < 15) begin
      if ($urandom_range(0, 1)) begin
        s.sx = r.x;
        s.sy = r.y;
      end
      s.ex = s.sx;
      s.ey = s.sy;
    end else if (pick < 25) begin
      // keep the raw random coordinates
    end else if (pick < 30) begin
      if ($urandom_range(0, 1)) s.ex = s.sx;
      else                      s.ey = s.sy;
    end else begin
      s = edge_segment(r);
    end
    return s;
  endfunction

  task automatic send_segment(input segment_t s);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.start_x <= s.sx;
    in_if.start_y <= s.sy;
    in_if.end_x   <= s.ex;
    in_if.end_y   <= s.ey;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [63:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
  endtask

  // Load all rectangles and the count, then poke unused indexes that must be dropped
  task automatic load_monitors(input logic [2:0] count, input int junk_writes);
    for (int i = 0; i < RECT_REGS; i++)
      write_register(3'(int'(REG_RECT0) + i), mon_rect[i]);
    write_register(REG_COUNT, {61'($urandom), count});
    for (int j = 0; j < junk_writes; j++)
      write_register(3'(int'(REG_RECT0) + RECT_REGS + j), {$urandom, $urandom});
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // Stop offering, let every outstanding result come back, then settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  initial begin : stimulus
    rect_t      prev;
    rect_mode_t mode;
    logic [2:0] cnt;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.start_x <= '0;
    in_if.start_y <= '0;
    in_if.end_x   <= '0;
    in_if.end_y   <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= '0;
    cfg_if.data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two side by side rectangles sharing the border x = 100
    mon_rect[0] = rect_of(0, 0, 100, 50);
    mon_rect[1] = rect_of(100, 0, 100, 50);
    mon_rect[2] = rect_of(-500, -500, 10, 10);
    mon_rect[3] = rect_of(1000, 1000, 10, 10);
    load_monitors(3'd2, 3);
    send_segment(seg(0, 0, 10, 10));
    send_segment(seg(5, 5, 5, 5));
    send_segment(seg(0, 10, 0, 40));
    send_segment(seg(100, 0, 100, 50));
    send_segment(seg(50, 10, 50, 20));
    send_segment(seg(0, -10, 0, 20));
    send_segment(seg(300, 0, 300, 10));
    send_segment(seg(90, 50, 10, 50));
    send_segment(seg(200, -5, 200, 0));
    send_segment(seg(0, 50, 0, 60));
    send_segment(seg(-32768, -32768, 32767, -32768));
    send_segment(seg(32767, 32767, 32767, -32768));
    send_segment(seg(-32768, 32767, 32767, -32768));
    send_segment(seg(-32768, -32768, -32768, -32768));
    send_segment(seg(32767, 32767, 32767, 32767));
    drain();

    // Count past the cap, a point rectangle and sums that run past 16 bits
    mon_rect[0] = '0;
    mon_rect[1] = rect_of(-32768, -32768, 65535, 65535);
    mon_rect[2] = rect_of(32767, 0, 65535, 10);
    mon_rect[3] = '1;
    load_monitors(3'd7, 0);
    send_segment(seg(0, -5, 0, 5));
    send_segment(seg(-32768, 100, -32768, 200));
    send_segment(seg(32767, 2, 32767, 8));
    send_segment(seg(100, 32767, 200, 32767));
    send_segment(seg(-1, -1, -1, -100));
    send_segment(seg(-32768, 0, -32767, 0));
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      prev = '0;
      for (int i = 0; i < RECT_REGS; i++) begin
        case (p)
          0, 1:    mode = RM_SMALL;
          2, 3:    mode = RM_TILE;
          5:       mode = RM_WIDE;
          6:       mode = RM_BOUND;
          default: mode = rect_mode_t'($urandom_range(0, 3));
        endcase
        if (i == 0 && mode == RM_TILE) mode = RM_SMALL;
        mon_rect[i] = make_rect(mode, prev);
        prev = mon_rect[i];
      end
      case (p)
        0:       cnt = 3'd0;
        1:       cnt = 3'd1;
        2:       cnt = 3'd2;
        3:       cnt = 3'd4;
        4:       cnt = 3'd7;
        6:       cnt = 3'd3;
        default: cnt = 3'($urandom_range(1, 7));
      endcase
      load_monitors(cnt, $urandom_range(0, 1));
      // Hold results off for a long stretch so the chain fills and stalls requests
      if (p == 2 || p == 7) hold_req = 1'b1;
      for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
        if (j % 20 == 0) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          rx_burst = ($urandom_range(0, 3) == 0);
        end
        send_segment(random_segment());
      end
      drain();
    end

    $display("Covered %0d segment requests over %0d register settings, %0d results",
             sb.requests, settings, sb.results_seen);
    $display("  with %0d hold-offs; status mix: accepted %0d, diagonal %0d, point %0d,",
             holds_done, sb.status_hits[ST_ACCEPTED], sb.status_hits[ST_NOT_ALIGNED],
             sb.status_hits[ST_POINT]);
    $display("  multiple %0d, overlap %0d, partial %0d, no edge %0d",
             sb.status_hits[ST_MULTIPLE], sb.status_hits[ST_OVERLAP],
             sb.status_hits[ST_PARTIAL], sb.status_hits[ST_NO_EDGE]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("Mismatches %0d, results still outstanding %0d", sb.mismatches, sb.pending());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
